### rtl/bcdt_pkg.sv
// Shared types, constants and helpers for the BCD countdown timer.
package bcdt_pkg;

	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [2:0] TENS_MAX  = 3'd5;

	// Configuration register indexes.
	localparam logic [2:0] CFG_COUNT_DOWN    = 3'd0;
	localparam logic [2:0] CFG_TENTH_PERIOD  = 3'd1;
	localparam logic [2:0] CFG_DEB_FALL      = 3'd2;
	localparam logic [2:0] CFG_DEB_RISE      = 3'd3;
	localparam logic [2:0] CFG_RESET_HOLD    = 3'd4;
	localparam logic [2:0] CFG_CHASE_PERIOD  = 3'd5;
	localparam logic [2:0] CFG_ALARM_BLINK   = 3'd6;
	localparam logic [2:0] CFG_BUZZER        = 3'd7;

	typedef struct packed {
		logic        button_minutes;
		logic        button_seconds;
		logic        button_run;
	} in_item_t;

	typedef struct packed {
		logic [3:0] tenths_digit;
		logic [3:0] seconds_units;
		logic [2:0] seconds_tens;
		logic [3:0] minutes_units;
		logic       running;
		logic       finished;
		logic [3:0] leds_lit;
		logic       buzzer_on;
	} out_item_t;

	typedef struct packed {
		logic [3:0] minutes_units;
		logic [2:0] seconds_tens;
		logic [3:0] seconds_units;
		logic [3:0] tenths_digit;
	} digits_t;

	typedef struct packed {
		logic        count_down;
		logic [15:0] tenth_period;
		logic [15:0] debounce_fall_ms;
		logic [15:0] debounce_rise_ms;
		logic [15:0] reset_hold_ms;
		logic [15:0] chase_period_ms;
		logic [15:0] alarm_blink_ms;
		logic [15:0] buzzer_ms;
	} cfg_t;

	// Events that a button raises during one transaction.
	typedef struct packed {
		logic press;
		logic hold_clear;
	} btn_evt_t;

	// True once more than limit milliseconds have gone by since stamp, modulo 2^32.
	function automatic logic elapsed(logic [31:0] now, logic [31:0] stamp, logic [15:0] limit);
		logic [31:0] diff;
		diff = now - stamp;
		return diff > {16'd0, limit};
	endfunction

endpackage

### rtl/bcdt_button.sv
// Debounce machine for one active-low button, with press and hold events.
module bcdt_button (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [31:0]         ms_now,
	input  logic                level,
	input  logic [15:0]         fall_ms,
	input  logic [15:0]         rise_ms,
	input  logic [15:0]         hold_ms,
	output bcdt_pkg::btn_evt_t  evt
);

	typedef enum logic [1:0] {
		BTN_IDLE = 2'd0,
		BTN_FALL = 2'd1,
		BTN_LOW  = 2'd2,
		BTN_RISE = 2'd3
	} btn_state_t;

	btn_state_t  state_q, state_d;
	logic [31:0] stamp_q, stamp_d;

	always_comb begin
		state_d = state_q;
		stamp_d = stamp_q;
		evt     = '0;
		unique case (state_q)
			BTN_IDLE: begin
				if (!level) begin
					stamp_d   = ms_now;
					evt.press = 1'b1;
					state_d   = BTN_FALL;
				end
			end
			BTN_FALL: begin
				if (bcdt_pkg::elapsed(ms_now, stamp_q, fall_ms)) begin
					state_d = BTN_LOW;
				end
			end
			BTN_LOW: begin
				if (level) begin
					stamp_d = ms_now;
					state_d = BTN_RISE;
				end else if (bcdt_pkg::elapsed(ms_now, stamp_q, hold_ms)) begin
					// A long hold restarts its own timing, so the event repeats.
					stamp_d        = ms_now;
					evt.hold_clear = 1'b1;
				end
			end
			BTN_RISE: begin
				if (bcdt_pkg::elapsed(ms_now, stamp_q, rise_ms)) begin
					state_d = BTN_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BTN_IDLE;
			stamp_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			stamp_q <= stamp_d;
		end
	end

endmodule

### rtl/bcdt_count.sv
// Digit counter with run and end flags, and the button edits applied after the count.
module bcdt_count (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                count_down,
	input  logic [15:0]         tenth_period,
	input  bcdt_pkg::btn_evt_t  evt_minutes,
	input  bcdt_pkg::btn_evt_t  evt_seconds,
	input  bcdt_pkg::btn_evt_t  evt_run,
	output bcdt_pkg::digits_t   digits_q,
	output logic                run_q,
	output logic                end_q,
	output logic                run_d,
	output logic                end_d
);

	bcdt_pkg::digits_t digits_d;
	logic [15:0]       tenth_q, tenth_d;

	always_comb begin
		digits_d = digits_q;
		tenth_d  = tenth_q;
		run_d    = run_q;
		end_d    = end_q;

		if (run_q) begin
			if (tenth_q < tenth_period) begin
				tenth_d = tenth_q + 16'd1;
			end else begin
				tenth_d = '0;
				end_d   = 1'b0;
				if (count_down) begin
					if (digits_q.tenths_digit != 4'd0) begin
						digits_d.tenths_digit = digits_q.tenths_digit - 4'd1;
					end else begin
						digits_d.tenths_digit = bcdt_pkg::DIGIT_MAX;
						if (digits_q.seconds_units != 4'd0) begin
							digits_d.seconds_units = digits_q.seconds_units - 4'd1;
						end else begin
							digits_d.seconds_units = bcdt_pkg::DIGIT_MAX;
							if (digits_q.seconds_tens != 3'd0) begin
								digits_d.seconds_tens = digits_q.seconds_tens - 3'd1;
							end else begin
								digits_d.seconds_tens = bcdt_pkg::TENS_MAX;
								if (digits_q.minutes_units != 4'd0) begin
									digits_d.minutes_units = digits_q.minutes_units - 4'd1;
								end else begin
									// Count-down holds at zero.
									digits_d = '0;
									end_d    = 1'b1;
								end
							end
						end
					end
				end else begin
					if (digits_q.tenths_digit < bcdt_pkg::DIGIT_MAX) begin
						digits_d.tenths_digit = digits_q.tenths_digit + 4'd1;
					end else begin
						digits_d.tenths_digit = 4'd0;
						if (digits_q.seconds_units < bcdt_pkg::DIGIT_MAX) begin
							digits_d.seconds_units = digits_q.seconds_units + 4'd1;
						end else begin
							digits_d.seconds_units = 4'd0;
							if (digits_q.seconds_tens < bcdt_pkg::TENS_MAX) begin
								digits_d.seconds_tens = digits_q.seconds_tens + 3'd1;
							end else begin
								digits_d.seconds_tens = 3'd0;
								if (digits_q.minutes_units < bcdt_pkg::DIGIT_MAX) begin
									digits_d.minutes_units = digits_q.minutes_units + 4'd1;
								end else begin
									// Count-up holds at the top value.
									digits_d.minutes_units = bcdt_pkg::DIGIT_MAX;
									digits_d.seconds_tens  = bcdt_pkg::TENS_MAX;
									digits_d.seconds_units = bcdt_pkg::DIGIT_MAX;
									digits_d.tenths_digit  = bcdt_pkg::DIGIT_MAX;
									end_d                  = 1'b1;
								end
							end
						end
					end
				end
			end
		end

		// Button edits come after the count, in button order.
		if (evt_minutes.press) begin
			digits_d.minutes_units = (digits_d.minutes_units >= bcdt_pkg::DIGIT_MAX) ?
				4'd0 : digits_d.minutes_units + 4'd1;
		end
		if (evt_seconds.press) begin
			if (digits_d.seconds_units >= bcdt_pkg::DIGIT_MAX) begin
				digits_d.seconds_units = 4'd0;
				digits_d.seconds_tens  = (digits_d.seconds_tens >= bcdt_pkg::TENS_MAX) ?
					3'd0 : digits_d.seconds_tens + 3'd1;
			end else begin
				digits_d.seconds_units = digits_d.seconds_units + 4'd1;
			end
		end
		if (evt_run.press) begin
			run_d = !run_d;
		end
		if (evt_run.hold_clear) begin
			digits_d = '0;
			run_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
			tenth_q  <= '0;
			run_q    <= 1'b0;
			end_q    <= 1'b0;
		end else if (step) begin
			digits_q <= digits_d;
			tenth_q  <= tenth_d;
			run_q    <= run_d;
			end_q    <= end_d;
		end
	end

endmodule

### rtl/bcdt_leds.sv
// LED chase while counting and the blink-then-buzz alarm once the count has ended.
module bcdt_leds #(
	parameter int BLINK_REPEATS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [31:0] ms_now,
	input  logic        run,
	input  logic        fin,
	input  logic [15:0] chase_period_ms,
	input  logic [15:0] alarm_blink_ms,
	input  logic [15:0] buzzer_ms,
	output logic [3:0]  leds_q,
	output logic        buzzer_q
);

	localparam int BW = $clog2(BLINK_REPEATS + 1);
	localparam logic [BW-1:0] REPEATS = BW'(BLINK_REPEATS);

	typedef enum logic [1:0] {
		CH_START = 2'd0,
		CH_ON    = 2'd1,
		CH_OFF   = 2'd2
	} chase_state_t;

	typedef enum logic [2:0] {
		AL_START  = 3'd0,
		AL_LEDON  = 3'd1,
		AL_LEDOFF = 3'd2,
		AL_BZON   = 3'd3,
		AL_BZOFF  = 3'd4
	} alarm_state_t;

	chase_state_t  chase_q, chase_d;
	logic [1:0]    index_q, index_d;
	logic [31:0]   chase_stamp_q, chase_stamp_d;
	alarm_state_t  alarm_q, alarm_d;
	logic [31:0]   alarm_stamp_q, alarm_stamp_d;
	logic [BW-1:0] blink_q, blink_d;
	logic [3:0]    leds_d;
	logic          buzzer_d;

	always_comb begin
		chase_d       = chase_q;
		index_d       = index_q;
		chase_stamp_d = chase_stamp_q;
		alarm_d       = alarm_q;
		alarm_stamp_d = alarm_stamp_q;
		blink_d       = blink_q;
		leds_d        = leds_q;
		buzzer_d      = buzzer_q;

		if (run && fin) begin
			unique case (alarm_q)
				AL_LEDON: begin
					if (bcdt_pkg::elapsed(ms_now, alarm_stamp_q, alarm_blink_ms)) begin
						alarm_stamp_d = ms_now;
						leds_d        = 4'hF;
						alarm_d       = AL_LEDOFF;
					end
				end
				AL_LEDOFF: begin
					if (bcdt_pkg::elapsed(ms_now, alarm_stamp_q, alarm_blink_ms)) begin
						leds_d        = 4'h0;
						buzzer_d      = 1'b0;
						alarm_stamp_d = ms_now;
						if (blink_q < REPEATS) begin
							blink_d = blink_q + BW'(1);
							alarm_d = AL_LEDON;
						end else begin
							blink_d = '0;
							alarm_d = AL_BZON;
						end
					end
				end
				AL_BZON: begin
					buzzer_d      = 1'b1;
					alarm_stamp_d = ms_now;
					alarm_d       = AL_BZOFF;
				end
				AL_BZOFF: begin
					if (bcdt_pkg::elapsed(ms_now, alarm_stamp_q, buzzer_ms)) begin
						buzzer_d = 1'b0;
						alarm_d  = AL_LEDON;
					end
				end
				default: begin
					leds_d   = 4'h0;
					buzzer_d = 1'b0;
					alarm_d  = AL_LEDON;
				end
			endcase
		end else if (run) begin
			unique case (chase_q)
				CH_ON: begin
					if (bcdt_pkg::elapsed(ms_now, chase_stamp_q, chase_period_ms)) begin
						chase_stamp_d = ms_now;
						leds_d        = leds_q & ~(4'b0001 << index_q);
						chase_d       = CH_OFF;
					end
				end
				CH_OFF: begin
					if (bcdt_pkg::elapsed(ms_now, chase_stamp_q, chase_period_ms)) begin
						chase_stamp_d = ms_now;
						chase_d       = CH_START;
						index_d       = index_q + 2'd1;
					end
				end
				default: begin
					buzzer_d = 1'b0;
					leds_d   = 4'b0001 << index_q;
					chase_d  = CH_ON;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chase_q       <= CH_START;
			index_q       <= '0;
			chase_stamp_q <= '0;
			alarm_q       <= AL_START;
			alarm_stamp_q <= '0;
			blink_q       <= '0;
			leds_q        <= '0;
			buzzer_q      <= 1'b0;
		end else if (step) begin
			chase_q       <= chase_d;
			index_q       <= index_d;
			chase_stamp_q <= chase_stamp_d;
			alarm_q       <= alarm_d;
			alarm_stamp_q <= alarm_stamp_d;
			blink_q       <= blink_d;
			leds_q        <= leds_d;
			buzzer_q      <= buzzer_d;
		end
	end

endmodule

### rtl/bcd_countdown_timer_with_alarm.sv
// Kitchen timer top level: the result of an accepted tick is registered and appears in the next cycle.
// Throughput is one tick per cycle; the state registers double as the output register,
// so input is stalled only while a finished result waits and the output side stalls.
// Asynchronous active-low reset clears the time, flags, button, chase and alarm state
// and loads the configuration registers with their default values.
module bcd_countdown_timer_with_alarm #(
	parameter int BLINK_REPEATS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bcdt_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bcdt_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_addr,
	input  logic [15:0]          cfg_wdata
);

	bcdt_pkg::cfg_t     cfg_q;
	logic [31:0]        ms_q;
	logic [31:0]        ms_now;
	logic               step;
	bcdt_pkg::btn_evt_t evt_min, evt_sec, evt_run;
	bcdt_pkg::digits_t  digits;
	logic               run_q, end_q, run_d, end_d;
	logic [3:0]         leds;
	logic               buzzer;

	assign in_stall = out_valid && out_stall;
	assign step     = in_valid && !in_stall;
	assign ms_now   = ms_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_down       <= 1'b1;
			cfg_q.tenth_period     <= 16'd99;
			cfg_q.debounce_fall_ms <= 16'd200;
			cfg_q.debounce_rise_ms <= 16'd100;
			cfg_q.reset_hold_ms    <= 16'd3999;
			cfg_q.chase_period_ms  <= 16'd124;
			cfg_q.alarm_blink_ms   <= 16'd74;
			cfg_q.buzzer_ms        <= 16'd149;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bcdt_pkg::CFG_COUNT_DOWN:   cfg_q.count_down       <= cfg_wdata[0];
				bcdt_pkg::CFG_TENTH_PERIOD: cfg_q.tenth_period     <= cfg_wdata;
				bcdt_pkg::CFG_DEB_FALL:     cfg_q.debounce_fall_ms <= cfg_wdata;
				bcdt_pkg::CFG_DEB_RISE:     cfg_q.debounce_rise_ms <= cfg_wdata;
				bcdt_pkg::CFG_RESET_HOLD:   cfg_q.reset_hold_ms    <= cfg_wdata;
				bcdt_pkg::CFG_CHASE_PERIOD: cfg_q.chase_period_ms  <= cfg_wdata;
				bcdt_pkg::CFG_ALARM_BLINK:  cfg_q.alarm_blink_ms   <= cfg_wdata;
				bcdt_pkg::CFG_BUZZER:       cfg_q.buzzer_ms        <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (step) begin
				ms_q <= ms_now;
			end
			if (step) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	bcdt_button u_btn_min (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ms_now  (ms_now),
		.level   (in_data.button_minutes),
		.fall_ms (cfg_q.debounce_fall_ms),
		.rise_ms (cfg_q.debounce_rise_ms),
		.hold_ms (cfg_q.reset_hold_ms),
		.evt     (evt_min)
	);

	bcdt_button u_btn_sec (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ms_now  (ms_now),
		.level   (in_data.button_seconds),
		.fall_ms (cfg_q.debounce_fall_ms),
		.rise_ms (cfg_q.debounce_rise_ms),
		.hold_ms (cfg_q.reset_hold_ms),
		.evt     (evt_sec)
	);

	bcdt_button u_btn_run (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.ms_now  (ms_now),
		.level   (in_data.button_run),
		.fall_ms (cfg_q.debounce_fall_ms),
		.rise_ms (cfg_q.debounce_rise_ms),
		.hold_ms (cfg_q.reset_hold_ms),
		.evt     (evt_run)
	);

	// Only the run button clears the timer on a long hold.
	bcdt_count u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.count_down   (cfg_q.count_down),
		.tenth_period (cfg_q.tenth_period),
		.evt_minutes  ('{press: evt_min.press, hold_clear: 1'b0}),
		.evt_seconds  ('{press: evt_sec.press, hold_clear: 1'b0}),
		.evt_run      (evt_run),
		.digits_q     (digits),
		.run_q        (run_q),
		.end_q        (end_q),
		.run_d        (run_d),
		.end_d        (end_d)
	);

	bcdt_leds #(
		.BLINK_REPEATS (BLINK_REPEATS)
	) u_leds (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.ms_now          (ms_now),
		.run             (run_d),
		.fin             (end_d),
		.chase_period_ms (cfg_q.chase_period_ms),
		.alarm_blink_ms  (cfg_q.alarm_blink_ms),
		.buzzer_ms       (cfg_q.buzzer_ms),
		.leds_q          (leds),
		.buzzer_q        (buzzer)
	);

	always_comb begin
		out_data.tenths_digit  = digits.tenths_digit;
		out_data.seconds_units = digits.seconds_units;
		out_data.seconds_tens  = digits.seconds_tens;
		out_data.minutes_units = digits.minutes_units;
		out_data.running       = run_q;
		out_data.finished      = end_q;
		out_data.leds_lit      = leds;
		out_data.buzzer_on     = buzzer;
	end

endmodule

### rtl/bcdt_checker.sv
// Port-level checks for the kitchen timer and the bind that attaches them.
module bcdt_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input bcdt_pkg::out_item_t  out_data
);

	// The input side only waits on a result that is held back.
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held result");

	// Every accepted transaction produces a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted transaction gave no result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

	// Digits always stay within their decimal ranges.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.tenths_digit <= 4'd9 && out_data.seconds_units <= 4'd9 &&
			out_data.seconds_tens <= 3'd5 && out_data.minutes_units <= 4'd9))
		else $error("digit out of range");

	// Without a new transaction and without a held result, the output is empty next cycle.
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && !in_stall) && !(out_valid && out_stall)) |=> !out_valid)
		else $error("result appeared without a transaction");

endmodule

bind bcd_countdown_timer_with_alarm bcdt_checker u_bcdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
